FILE: rtl/core/ehp_pkg.sv
// Shared types and constants for the Ethernet / 802.1Q / MPLS header parser.
package ehp_pkg;

  // Reset values of the configuration registers
  localparam logic [15:0] VLAN_TPID_RST         = 16'h8100;
  localparam logic [15:0] MPLS_TYPE_RST         = 16'h8847;
  localparam logic [15:0] MPLS_PAYLOAD_TYPE_RST = 16'h0800;

  // Configuration register indexes
  localparam logic [1:0] CFG_VLAN_TPID         = 2'd0;
  localparam logic [1:0] CFG_MPLS_TYPE         = 2'd1;
  localparam logic [1:0] CFG_MPLS_PAYLOAD_TYPE = 2'd2;

  // Byte offsets inside the Ethernet II header
  localparam logic [7:0] ETH_SRC_START  = 8'd6;
  localparam logic [7:0] ETH_TYPE_START = 8'd12;
  localparam logic [7:0] ETH_LAST_BYTE  = 8'd13;

  // Last byte position inside a 4-byte tag or label
  localparam logic [1:0] WORD_LAST_POS = 2'd3;

  // Depth of the queue between the parser front and the record back end
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ETH  = 2'd1,
    ST_VLAN = 2'd2,
    ST_MPLS = 2'd3
  } ehp_stage_t;

  typedef enum logic [1:0] {
    KIND_ETH  = 2'd0,
    KIND_VLAN = 2'd1,
    KIND_MPLS = 2'd2,
    KIND_SUM  = 2'd3
  } ehp_kind_t;

  typedef struct packed {
    logic [15:0] vlan_tpid;
    logic [15:0] mpls_type;
    logic [15:0] mpls_payload_type;
  } ehp_cfg_t;

  // One result record as it leaves the block
  typedef struct packed {
    ehp_kind_t   kind;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] type_value;
    logic [2:0]  priority_bits;
    logic        flag_bit;
    logic [19:0] tag_value;
    logic [7:0]  hop_limit;
    logic [7:0]  l3_offset;
    logic        overflow;
    logic        last;
  } ehp_rec_t;

  // Queue entry: one header record, optionally followed by a summary
  typedef struct packed {
    ehp_kind_t   kind;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [15:0] type_value;
    logic [2:0]  priority_bits;
    logic        flag_bit;
    logic [19:0] tag_value;
    logic [7:0]  hop_limit;
    logic        has_sum;
    logic [15:0] sum_type;
    logic [7:0]  sum_offset;
    logic        sum_overflow;
  } ehp_entry_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } ehp_qstat_t;

endpackage

FILE: rtl/core/ehp_if.sv
// Valid/ready channel interfaces for frame bytes and parsed records.
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [15:0] type_value;
  logic [2:0]  priority_bits;
  logic        flag_bit;
  logic [19:0] tag_value;
  logic [7:0]  hop_limit;
  logic [7:0]  l3_offset;
  logic        overflow;
  logic        last;

  modport source (
    output valid, output record_kind, output dest_mac, output source_mac,
    output type_value, output priority_bits, output flag_bit, output tag_value,
    output hop_limit, output l3_offset, output overflow, output last,
    input ready
  );
  modport sink (
    input valid, input record_kind, input dest_mac, input source_mac,
    input type_value, input priority_bits, input flag_bit, input tag_value,
    input hop_limit, input l3_offset, input overflow, input last,
    output ready
  );
endinterface

FILE: rtl/core/ehp_front.sv
// Byte-level parser front end: walks the headers and queues one entry per header.
module ehp_front #(
  parameter int unsigned MAX_VLAN_TAGS   = 4,
  parameter int unsigned MAX_MPLS_LABELS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  ehp_in_if.sink              in_ch,
  input  ehp_pkg::ehp_cfg_t   cfg,
  input  ehp_pkg::ehp_qstat_t qstat,
  output logic                push,
  output ehp_pkg::ehp_entry_t entry
);
  import ehp_pkg::*;

  localparam int unsigned VC_W = $clog2(MAX_VLAN_TAGS + 1);
  localparam int unsigned LC_W = $clog2(MAX_MPLS_LABELS + 1);
  localparam logic [VC_W-1:0] VC_MAX = VC_W'(MAX_VLAN_TAGS);
  localparam logic [LC_W-1:0] LC_MAX = LC_W'(MAX_MPLS_LABELS);

  ehp_stage_t      stage_r, stage_nxt, stg_c;
  logic [1:0]      bpos_r, bpos_nxt, bpos_c;
  logic [7:0]      off_r, off_nxt, off_c, off_inc;
  logic [VC_W-1:0] vc_r, vc_nxt, vc_c, vc_inc;
  logic [LC_W-1:0] lc_r, lc_nxt, lc_c, lc_inc;
  logic [47:0]     dest_r, dest_nxt;
  logic [47:0]     src_r, src_nxt;
  logic [31:0]     word_r, word_nxt, word_w;
  logic [15:0]     eth_type;
  logic            accept;

  // Stage that follows a header whose next type is t; idle means summary now
  function automatic ehp_stage_t follow_stage(input logic [15:0] t,
                                              input ehp_cfg_t    c,
                                              input logic        vlan_full);
    ehp_stage_t s;
    if (t == c.vlan_tpid) begin
      s = vlan_full ? ST_IDLE : ST_VLAN;
    end else if (t == c.mpls_type) begin
      s = ST_MPLS;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && !qstat.full;

  // A first byte restarts the walk before the byte is processed
  always_comb begin
    stg_c  = in_ch.first_byte ? ST_ETH : stage_r;
    bpos_c = in_ch.first_byte ? 2'd0 : bpos_r;
    off_c  = in_ch.first_byte ? 8'd0 : off_r;
    vc_c   = in_ch.first_byte ? '0 : vc_r;
    lc_c   = in_ch.first_byte ? '0 : lc_r;
  end

  assign off_inc  = off_c + 8'd1;
  assign vc_inc   = vc_c + VC_W'(1);
  assign lc_inc   = lc_c + LC_W'(1);
  assign word_w   = {word_r[23:0], in_ch.data_byte};
  assign eth_type = {word_r[7:0], in_ch.data_byte};

  // Header walk
  always_comb begin
    stage_nxt = stage_r;
    bpos_nxt  = bpos_r;
    off_nxt   = off_r;
    vc_nxt    = vc_r;
    lc_nxt    = lc_r;
    dest_nxt  = dest_r;
    src_nxt   = src_r;
    word_nxt  = word_r;
    push      = 1'b0;
    entry     = '0;
    if (accept && stg_c != ST_IDLE) begin
      stage_nxt = stg_c;
      bpos_nxt  = bpos_c;
      off_nxt   = off_inc;
      vc_nxt    = vc_c;
      lc_nxt    = lc_c;
      entry.sum_offset = off_inc;
      unique case (stg_c)
        ST_ETH: begin
          if (off_c < ETH_SRC_START) begin
            dest_nxt = {dest_r[39:0], in_ch.data_byte};
          end else if (off_c < ETH_TYPE_START) begin
            src_nxt = {src_r[39:0], in_ch.data_byte};
          end else begin
            word_nxt = word_w;
          end
          if (off_c == ETH_LAST_BYTE) begin
            push             = 1'b1;
            entry.kind       = KIND_ETH;
            entry.dest_mac   = dest_r;
            entry.source_mac = src_r;
            entry.type_value = eth_type;
            stage_nxt        = follow_stage(eth_type, cfg, vc_c >= VC_MAX);
            bpos_nxt         = 2'd0;
            entry.has_sum      = (stage_nxt == ST_IDLE);
            entry.sum_type     = eth_type;
            entry.sum_overflow = (eth_type == cfg.vlan_tpid);
          end
        end
        ST_VLAN: begin
          word_nxt = word_w;
          bpos_nxt = bpos_c + 2'd1;
          if (bpos_c == WORD_LAST_POS) begin
            push                = 1'b1;
            entry.kind          = KIND_VLAN;
            entry.type_value    = word_w[15:0];
            entry.priority_bits = word_w[31:29];
            entry.flag_bit      = word_w[28];
            entry.tag_value     = {8'd0, word_w[27:16]};
            vc_nxt              = vc_inc;
            stage_nxt           = follow_stage(word_w[15:0], cfg, vc_inc >= VC_MAX);
            entry.has_sum       = (stage_nxt == ST_IDLE);
            entry.sum_type      = word_w[15:0];
            entry.sum_overflow  = (word_w[15:0] == cfg.vlan_tpid);
          end
        end
        ST_MPLS: begin
          word_nxt = word_w;
          bpos_nxt = bpos_c + 2'd1;
          if (bpos_c == WORD_LAST_POS) begin
            push                = 1'b1;
            entry.kind          = KIND_MPLS;
            entry.priority_bits = word_w[11:9];
            entry.flag_bit      = word_w[8];
            entry.tag_value     = word_w[31:12];
            entry.hop_limit     = word_w[7:0];
            lc_nxt              = lc_inc;
            // Bottom of stack wins over the label limit
            if (word_w[8]) begin
              stage_nxt      = ST_IDLE;
              entry.has_sum  = 1'b1;
              entry.sum_type = cfg.mpls_payload_type;
            end else if (lc_inc >= LC_MAX) begin
              stage_nxt          = ST_IDLE;
              entry.has_sum      = 1'b1;
              entry.sum_type     = cfg.mpls_type;
              entry.sum_overflow = 1'b1;
            end
          end
        end
        default: begin
          stage_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_IDLE;
      bpos_r  <= 2'd0;
      off_r   <= 8'd0;
      vc_r    <= '0;
      lc_r    <= '0;
    end else begin
      stage_r <= stage_nxt;
      bpos_r  <= bpos_nxt;
      off_r   <= off_nxt;
      vc_r    <= vc_nxt;
      lc_r    <= lc_nxt;
    end
  end

  // Header field shifters, fully rewritten before each use
  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
    src_r  <= src_nxt;
    word_r <= word_nxt;
  end

endmodule

FILE: rtl/core/ehp_queue.sv
// Small FIFO of parsed header entries between the front and back ends.
module ehp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ehp_pkg::ehp_entry_t  push_entry,
  input  logic                 pop,
  output ehp_pkg::ehp_entry_t  head,
  output ehp_pkg::ehp_qstat_t  qstat
);
  import ehp_pkg::*;

  ehp_entry_t             slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;
  logic                   do_push, do_pop;

  assign qstat.full  = (count_r == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slot_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/core/ehp_back.sv
// Record back end: expands queue entries into records behind an output register.
module ehp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ehp_pkg::ehp_entry_t  head,
  input  ehp_pkg::ehp_qstat_t  qstat,
  output logic                 pop,
  ehp_out_if.source            out_ch
);
  import ehp_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        sum_pend_r, sum_pend_nxt;
  ehp_rec_t    rec_r, rec_nxt;
  logic [15:0] sum_type_r;
  logic [7:0]  sum_off_r;
  logic        sum_ovf_r;
  logic        load;

  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !sum_pend_r && !qstat.empty;

  // Pick the next record: a pending summary goes before the next entry
  always_comb begin
    out_valid_nxt = out_valid_r;
    sum_pend_nxt  = sum_pend_r;
    rec_nxt       = rec_r;
    if (load) begin
      out_valid_nxt = sum_pend_r || !qstat.empty;
      if (sum_pend_r) begin
        sum_pend_nxt       = 1'b0;
        rec_nxt            = '0;
        rec_nxt.kind       = KIND_SUM;
        rec_nxt.type_value = sum_type_r;
        rec_nxt.l3_offset  = sum_off_r;
        rec_nxt.overflow   = sum_ovf_r;
        rec_nxt.last       = 1'b1;
      end else if (!qstat.empty) begin
        sum_pend_nxt          = head.has_sum;
        rec_nxt               = '0;
        rec_nxt.kind          = head.kind;
        rec_nxt.dest_mac      = head.dest_mac;
        rec_nxt.source_mac    = head.source_mac;
        rec_nxt.type_value    = head.type_value;
        rec_nxt.priority_bits = head.priority_bits;
        rec_nxt.flag_bit      = head.flag_bit;
        rec_nxt.tag_value     = head.tag_value;
        rec_nxt.hop_limit     = head.hop_limit;
        rec_nxt.last          = !head.has_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sum_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sum_pend_r  <= sum_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (pop) begin
      sum_type_r <= head.sum_type;
      sum_off_r  <= head.sum_offset;
      sum_ovf_r  <= head.sum_overflow;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.record_kind   = rec_r.kind;
  assign out_ch.dest_mac      = rec_r.dest_mac;
  assign out_ch.source_mac    = rec_r.source_mac;
  assign out_ch.type_value    = rec_r.type_value;
  assign out_ch.priority_bits = rec_r.priority_bits;
  assign out_ch.flag_bit      = rec_r.flag_bit;
  assign out_ch.tag_value     = rec_r.tag_value;
  assign out_ch.hop_limit     = rec_r.hop_limit;
  assign out_ch.l3_offset     = rec_r.l3_offset;
  assign out_ch.overflow      = rec_r.overflow;
  assign out_ch.last          = rec_r.last;

endmodule

FILE: rtl/core/ethernet_vlan_mpls_header_parser_unit.sv
// Top level of the Ethernet II / 802.1Q / MPLS header parser.
//
// in_ch carries frame bytes in wire order; first_byte marks byte 0 of a frame
// and restarts the parse. out_ch carries one record per parsed header (Ethernet,
// VLAN tag, MPLS label) and a summary record with the L3 offset and protocol;
// last marks the final record caused by one byte. Bytes after the summary and
// bytes seen while idle produce nothing.
// Throughput: one byte per clock while the entry queue has room. A byte that
// completes a header yields one record (and a summary record when the walk
// ends); the output port moves one record per clock while the receiver is ready,
// so header bytes outrun records only briefly. A record is written into the entry
// queue on the edge that accepts the byte completing it and is then loaded into
// the output register once that register is empty or taken; a summary record follows it.
// When the receiver stalls, the output register holds, the 4-entry queue fills,
// and in_ch.ready drops once the queue is full.
// Reset (rst_n, synchronous) idles the parser, empties the queue and restores
// the type registers to 0x8100, 0x8847 and 0x0800. cfg_we writes register
// cfg_addr (0 VLAN TPID, 1 MPLS type, 2 MPLS payload type).
module ethernet_vlan_mpls_header_parser_unit #(
  parameter int unsigned MAX_VLAN_TAGS   = 4,
  parameter int unsigned MAX_MPLS_LABELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ehp_in_if.sink      in_ch,
  ehp_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import ehp_pkg::*;

  ehp_cfg_t   cfg_r;
  ehp_entry_t push_entry;
  ehp_entry_t head;
  ehp_qstat_t qstat;
  logic       push;
  logic       pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vlan_tpid         <= VLAN_TPID_RST;
      cfg_r.mpls_type         <= MPLS_TYPE_RST;
      cfg_r.mpls_payload_type <= MPLS_PAYLOAD_TYPE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_VLAN_TPID:         cfg_r.vlan_tpid         <= cfg_wdata;
        CFG_MPLS_TYPE:         cfg_r.mpls_type         <= cfg_wdata;
        CFG_MPLS_PAYLOAD_TYPE: cfg_r.mpls_payload_type <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ehp_front #(
    .MAX_VLAN_TAGS  (MAX_VLAN_TAGS),
    .MAX_MPLS_LABELS(MAX_MPLS_LABELS)
  ) u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg  (cfg_r),
    .qstat(qstat),
    .push (push),
    .entry(push_entry)
  );

  ehp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ehp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

FILE: tb/tb_ethernet_vlan_mpls_header_parser_unit.sv
// Self-checking testbench for the Ethernet / 802.1Q / MPLS header parser unit.
module tb_ethernet_vlan_mpls_header_parser_unit;
  import ehp_pkg::*;

  localparam int unsigned MAX_TAGS    = 4;
  localparam int unsigned MAX_LABELS  = 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SHOW_LIMIT  = 10;

  // What follows the last 802.1Q tag of a generated frame
  typedef enum int unsigned {
    TAIL_L3,
    TAIL_MPLS,
    TAIL_TAG
  } frame_tail_t;

  // One frame byte waiting for the driver
  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } wire_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  ehp_in_if  in_if ();
  ehp_out_if out_if ();

  ethernet_vlan_mpls_header_parser_unit #(
    .MAX_VLAN_TAGS   (MAX_TAGS),
    .MAX_MPLS_LABELS (MAX_LABELS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Byte backlog, expected records and run bookkeeping
  wire_byte_t  byte_backlog[$];
  ehp_rec_t    expected_recs[$];
  ehp_rec_t    byte_recs[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned bytes_accepted = 0;
  int unsigned records_checked = 0;
  int unsigned frames_queued  = 0;
  int unsigned configs_run    = 1;
  int unsigned quiet_cycles   = 0;

  // Parser state mirrored by the predictor
  ehp_stage_t  pr_stage;
  logic [2:0]  pr_pos;
  logic [47:0] pr_dest;
  logic [47:0] pr_src;
  logic [31:0] pr_word;
  logic [4:0]  pr_tags;
  logic [4:0]  pr_labels;
  logic [7:0]  pr_offset;
  ehp_cfg_t    pr_cfg;

  function automatic ehp_rec_t blank_rec(ehp_kind_t k);
    ehp_rec_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // Summary record; the parser goes idle until the next first byte
  task automatic close_frame(logic [15:0] proto, logic ovf);
    ehp_rec_t r;
    r = blank_rec(KIND_SUM);
    r.type_value = proto;
    r.l3_offset  = pr_offset;
    r.overflow   = ovf;
    byte_recs.push_back(r);
    pr_stage = ST_IDLE;
  endtask

  // Choose the next header from the type just parsed; tag check wins on equal types
  task automatic next_header(logic [15:0] t);
    pr_pos  = '0;
    pr_word = '0;
    if (t == pr_cfg.vlan_tpid) begin
      if (pr_tags >= MAX_TAGS) close_frame(t, 1'b1);
      else pr_stage = ST_VLAN;
    end else if (t == pr_cfg.mpls_type) begin
      pr_stage = ST_MPLS;
    end else begin
      close_frame(t, 1'b0);
    end
  endtask

  // Predict the records caused by one accepted frame byte
  task automatic parse_byte(logic [7:0] b, logic first);
    ehp_rec_t    r;
    logic [31:0] w;
    byte_recs.delete();
    if (first) begin
      pr_stage  = ST_ETH;
      pr_pos    = '0;
      pr_dest   = '0;
      pr_src    = '0;
      pr_word   = '0;
      pr_tags   = '0;
      pr_labels = '0;
      pr_offset = '0;
    end
    if (pr_stage == ST_ETH) begin
      if (pr_offset < ETH_SRC_START) pr_dest = {pr_dest[39:0], b};
      else if (pr_offset < ETH_TYPE_START) pr_src = {pr_src[39:0], b};
      else pr_word = {16'h0, pr_word[7:0], b};
      pr_offset = pr_offset + 8'd1;
      if (pr_offset > ETH_LAST_BYTE) begin
        r = blank_rec(KIND_ETH);
        r.dest_mac   = pr_dest;
        r.source_mac = pr_src;
        r.type_value = pr_word[15:0];
        byte_recs.push_back(r);
        next_header(pr_word[15:0]);
      end
    end else if (pr_stage != ST_IDLE) begin
      pr_word   = {pr_word[23:0], b};
      pr_offset = pr_offset + 8'd1;
      pr_pos    = pr_pos + 3'd1;
      if (pr_pos > WORD_LAST_POS) begin
        w = pr_word;
        if (pr_stage == ST_VLAN) begin
          // TCI: PCP, CFI, VID, then the next type
          r = blank_rec(KIND_VLAN);
          r.type_value    = w[15:0];
          r.priority_bits = w[31:29];
          r.flag_bit      = w[28];
          r.tag_value     = {8'h0, w[27:16]};
          byte_recs.push_back(r);
          pr_tags = pr_tags + 5'd1;
          next_header(w[15:0]);
        end else begin
          // Label word: LABEL, EXP, S, TTL
          r = blank_rec(KIND_MPLS);
          r.priority_bits = w[11:9];
          r.flag_bit      = w[8];
          r.tag_value     = w[31:12];
          r.hop_limit     = w[7:0];
          byte_recs.push_back(r);
          pr_labels = pr_labels + 5'd1;
          pr_pos    = '0;
          pr_word   = '0;
          if (w[8]) close_frame(pr_cfg.mpls_payload_type, 1'b0);
          else if (pr_labels >= MAX_LABELS) close_frame(pr_cfg.mpls_type, 1'b1);
        end
      end
    end
    if (byte_recs.size() != 0) byte_recs[byte_recs.size() - 1].last = 1'b1;
    foreach (byte_recs[i]) expected_recs.push_back(byte_recs[i]);
  endtask

  function automatic logic [47:0] rand_mac();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [15:0] rand_type();
    case ($urandom_range(15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h86DD;
      default: return 16'($urandom);
    endcase
  endfunction

  // Build one frame and queue its bytes; returns the number of bytes queued
  function automatic int unsigned queue_frame(logic [47:0] dest, logic [47:0] src,
                                              int unsigned n_tags, frame_tail_t tail,
                                              logic [15:0] l3_type, int unsigned n_labels,
                                              bit bos_last, int unsigned trail,
                                              int unsigned cut_len);
    logic [7:0]  fb[$];
    logic [15:0] tail_type;
    logic [31:0] w;
    case (tail)
      TAIL_MPLS: tail_type = pr_cfg.mpls_type;
      TAIL_TAG:  tail_type = pr_cfg.vlan_tpid;
      default:   tail_type = l3_type;
    endcase
    for (int i = 5; i >= 0; i--) fb.push_back(dest[i*8 +: 8]);
    for (int i = 5; i >= 0; i--) fb.push_back(src[i*8 +: 8]);
    w[15:0] = (n_tags > 0) ? pr_cfg.vlan_tpid : tail_type;
    fb.push_back(w[15:8]);
    fb.push_back(w[7:0]);
    for (int h = 1; h <= n_tags; h++) begin
      w = $urandom;
      w[15:0] = (h < n_tags) ? pr_cfg.vlan_tpid : tail_type;
      for (int i = 3; i >= 0; i--) fb.push_back(w[i*8 +: 8]);
    end
    if (tail == TAIL_MPLS) begin
      for (int l = 0; l < n_labels; l++) begin
        w = $urandom;
        w[8] = bos_last && (l == n_labels - 1);
        for (int i = 3; i >= 0; i--) fb.push_back(w[i*8 +: 8]);
      end
    end
    repeat (trail) fb.push_back(8'($urandom));
    if (cut_len != 0) begin
      while (fb.size() > cut_len) void'(fb.pop_back());
    end
    foreach (fb[i]) byte_backlog.push_back('{first: (i == 0), data: fb[i]});
    frames_queued++;
    return fb.size();
  endfunction

  // Mostly well-formed frames, with idle noise and truncated frames mixed in
  task automatic queue_random_traffic(int unsigned n_bytes);
    int unsigned filled = 0;
    int unsigned sel;
    int unsigned tags;
    frame_tail_t tail;
    while (filled < n_bytes) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 4))
          byte_backlog.push_back('{first: ($urandom_range(9) == 0), data: 8'($urandom)});
      end else begin
        sel  = $urandom_range(99);
        tail = (sel < 40) ? TAIL_L3 : (sel < 85) ? TAIL_MPLS : TAIL_TAG;
        tags = (tail == TAIL_TAG) ? MAX_TAGS : $urandom_range(0, MAX_TAGS);
        filled += queue_frame(rand_mac(), rand_mac(), tags, tail, rand_type(),
                              $urandom_range(1, ($urandom_range(3) == 0) ? MAX_LABELS : 3),
                              ($urandom_range(99) < 85), $urandom_range(0, 6),
                              ($urandom_range(99) < 10) ? $urandom_range(1, 40) : 0);
      end
    end
  endtask

  // Wait for all bytes sent and all records seen, plus the pipeline latency
  task automatic wait_idle();
    @(negedge clk);
    while (byte_backlog.size() != 0 || in_if.valid || expected_recs.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write all three type registers back to back
  task automatic set_config(logic [15:0] tpid, logic [15:0] mtype, logic [15:0] ptype);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_VLAN_TPID;
    cfg_wdata <= tpid;
    @(posedge clk);
    cfg_addr  <= CFG_MPLS_TYPE;
    cfg_wdata <= mtype;
    @(posedge clk);
    cfg_addr  <= CFG_MPLS_PAYLOAD_TYPE;
    cfg_wdata <= ptype;
    @(posedge clk);
    cfg_we    <= 1'b0;
    pr_cfg = '{vlan_tpid: tpid, mpls_type: mtype, mpls_payload_type: ptype};
  endtask

  task automatic run_phase(logic [15:0] tpid, logic [15:0] mtype, logic [15:0] ptype,
                           int unsigned send_pct, int unsigned recv_pct,
                           int unsigned n_bytes);
    wait_idle();
    set_config(tpid, mtype, ptype);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_random_traffic(n_bytes);
    configs_run++;
  endtask

  // Driver: present backlog bytes, predict each accepted transaction
  always @(posedge clk) begin
    wire_byte_t nb;
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.data_byte  <= '0;
      in_if.first_byte <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.data_byte, in_if.first_byte);
        bytes_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = byte_backlog.pop_front();
          in_if.valid      <= 1'b1;
          in_if.data_byte  <= nb.data;
          in_if.first_byte <= nb.first;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each record with the oldest expectation
  always @(posedge clk) begin
    ehp_rec_t got;
    ehp_rec_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_if.valid && out_if.ready) begin
        got.kind          = ehp_kind_t'(out_if.record_kind);
        got.dest_mac      = out_if.dest_mac;
        got.source_mac    = out_if.source_mac;
        got.type_value    = out_if.type_value;
        got.priority_bits = out_if.priority_bits;
        got.flag_bit      = out_if.flag_bit;
        got.tag_value     = out_if.tag_value;
        got.hop_limit     = out_if.hop_limit;
        got.l3_offset     = out_if.l3_offset;
        got.overflow      = out_if.overflow;
        got.last          = out_if.last;
        records_checked++;
        if (expected_recs.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: record with none expected: %p", $time, got);
        end else begin
          want = expected_recs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("%0t: record mismatch", $time);
              $display("  expected %p", want);
              $display("  actual   %p", got);
            end
          end
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles, %0d records outstanding",
             $time, QUIET_LIMIT, expected_recs.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = CFG_VLAN_TPID;
    cfg_wdata        = '0;
    pr_stage  = ST_IDLE;
    pr_pos    = '0;
    pr_dest   = '0;
    pr_src    = '0;
    pr_word   = '0;
    pr_tags   = '0;
    pr_labels = '0;
    pr_offset = '0;
    pr_cfg    = '{vlan_tpid: VLAN_TPID_RST, mpls_type: MPLS_TYPE_RST,
                  mpls_payload_type: MPLS_PAYLOAD_TYPE_RST};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames on the reset register values
    byte_backlog.push_back('{first: 1'b0, data: 8'hFF});
    byte_backlog.push_back('{first: 1'b0, data: 8'h00});
    void'(queue_frame('1, '0, 0, TAIL_L3, 16'h0800, 1, 1, 2, 0));
    void'(queue_frame(rand_mac(), rand_mac(), 0, TAIL_L3, 16'h0800, 1, 1, 0, 5));
    void'(queue_frame(rand_mac(), rand_mac(), 1, TAIL_L3, 16'h86DD, 1, 1, 1, 0));
    void'(queue_frame(rand_mac(), rand_mac(), MAX_TAGS, TAIL_TAG, 16'h0800, 1, 1, 3, 0));
    void'(queue_frame(rand_mac(), rand_mac(), 0, TAIL_MPLS, 16'h0800, 1, 1, 2, 0));
    void'(queue_frame(rand_mac(), rand_mac(), 2, TAIL_MPLS, 16'h0800, MAX_LABELS, 0, 2, 0));
    void'(queue_frame('0, '1, 3, TAIL_MPLS, 16'h0800, 3, 1, 0, 0));
    void'(queue_frame(rand_mac(), rand_mac(), 0, TAIL_L3, 16'hFFFF, 1, 1, 0, 0));
    void'(queue_frame(rand_mac(), rand_mac(), 0, TAIL_L3, 16'h0000, 1, 1, 0, 0));

    // Random phases over several register settings and idle patterns
    run_phase(16'h8100, 16'h8847, 16'h0800,  0,  0, 190);
    run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 46,  0, 190);
    run_phase(16'h0000, 16'hFFFF, 16'h0000,  0, 46, 190);
    run_phase(16'h88A8, 16'h88A8, 16'h86DD, 35, 35, 190);  // equal tag and label types
    run_phase(16'($urandom), 16'($urandom), 16'($urandom), 46, 0, 190);
    run_phase(16'h8100, 16'h8847, 16'h0800, 35, 35, 190);
    wait_idle();

    $display("Sent %0d frames as %0d bytes under %0d register settings;",
             frames_queued, bytes_accepted, configs_run);
    $display("checked %0d records, %0d mismatches, %0d records never seen",
             records_checked, mismatches, expected_recs.size());
    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
